>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on the rising clock, off while reset is low
`define WLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same, with a caller message
`define WLC_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

>>> design/wlc_pkg.sv
// ----------------------------------------------------------------------------
// wlc_pkg
// types, codes and defaults shared by the server picker modules
// ----------------------------------------------------------------------------
package wlc_pkg;

  localparam int unsigned MAX_SERVERS_DEF = 16;
  localparam int unsigned CONN_WIDTH_DEF  = 16;
  localparam int unsigned COST_SCALE      = 1000;
  localparam int unsigned LIFE_W          = 32;
  localparam int unsigned ENT_W           = 25;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_PICK    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_SERVER = 2'd1;
  localparam logic [1:0] ERR_ZERO_REL  = 2'd2;

  localparam logic CFG_MASK  = 1'b0;
  localparam logic CFG_VALUE = 1'b1;

  localparam int unsigned ST_RUNNING = 0;
  localparam int unsigned ST_MASTER  = 1;
  localparam int unsigned ST_SLAVE   = 2;
  localparam int unsigned ST_MAINT   = 5;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_REL_RD, S_REL_WR, S_M_RD, S_M_EVAL, S_C_RD, S_C_EVAL,
    S_C_DIV, S_C_CMP, S_FALLBACK, S_UPD_RD, S_UPD_WR, S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    ADDR_IDX, ADDR_PTR, ADDR_CAND
  } addr_sel_e;

  typedef struct packed {
    logic      latch;
    logic      ptr_clr;
    logic      ptr_inc;
    addr_sel_e addr_sel;
    logic      ent_we;
    logic      cnt_wr_rel;
    logic      cnt_wr_pick;
    logic      m_clr;
    logic      m_eval;
    logic      c_clr;
    logic      div_start;
    logic      c_take;
    logic      c_set_master;
    logic      c_set_none;
    logic      c_fallback;
    logic      res_load;
  } cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic elig;
    logic is_master;
    logic m_vld;
    logic fv_slave;
    logic fv_master;
    logic div_busy;
    logic better;
    logic c_vld;
    logic out_busy;
  } sts_t;

endpackage

>>> design/wlc_ram.sv
// ----------------------------------------------------------------------------
// wlc_ram
// generic single port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module wlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/wlc_div.sv
// ----------------------------------------------------------------------------
// wlc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wlc_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 10,
  localparam int unsigned CNT_W = $clog2(NUM_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] q_q, q_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    trial  = {rem_q, q_q[NUM_W-1]};
    rem_d  = rem_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      q_d    = num_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        q_d   = {q_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        q_d   = {q_q[NUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule

>>> design/wlc_ctrl.sv
// ----------------------------------------------------------------------------
// wlc_ctrl
// sequencer for entry write, release and the two pass pick scan
// ----------------------------------------------------------------------------
module wlc_ctrl
  import wlc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_WRITE:   state_d = S_WRITE;
            MODE_PICK:    state_d = S_M_RD;
            MODE_RELEASE: state_d = S_REL_RD;
            default:      state_d = S_RESULT;
          endcase
        end
      end
      S_WRITE:  state_d = S_RESULT;
      S_REL_RD: state_d = S_REL_WR;
      S_REL_WR: state_d = S_RESULT;
      S_M_RD:   state_d = S_M_EVAL;
      S_M_EVAL: state_d = sts_i.ptr_last ? S_C_RD : S_M_RD;
      S_C_RD:   state_d = S_C_EVAL;
      S_C_EVAL: begin
        if (!sts_i.elig || (sts_i.m_vld && sts_i.is_master && sts_i.fv_slave)) begin
          state_d = sts_i.ptr_last ? S_FALLBACK : S_C_RD;
        end else if ((sts_i.m_vld && sts_i.is_master && sts_i.fv_master) ||
                     (!sts_i.m_vld && sts_i.fv_master)) begin
          state_d = S_FALLBACK;
        end else begin
          state_d = S_C_DIV;
        end
      end
      S_C_DIV:    state_d = sts_i.div_busy ? S_C_DIV : S_C_CMP;
      S_C_CMP:    state_d = sts_i.ptr_last ? S_FALLBACK : S_C_RD;
      S_FALLBACK: state_d = S_UPD_RD;
      S_UPD_RD:   state_d = S_UPD_WR;
      S_UPD_WR:   state_d = S_RESULT;
      S_RESULT:   state_d = sts_i.out_busy ? S_RESULT : S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_PTR;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.latch   = in_valid_i;
        cmd_o.ptr_clr = 1'b1;
        cmd_o.m_clr   = 1'b1;
        cmd_o.c_clr   = 1'b1;
      end
      S_WRITE: begin
        cmd_o.addr_sel = ADDR_IDX;
        cmd_o.ent_we   = 1'b1;
      end
      S_REL_RD: cmd_o.addr_sel = ADDR_IDX;
      S_REL_WR: begin
        cmd_o.addr_sel   = ADDR_IDX;
        cmd_o.cnt_wr_rel = 1'b1;
      end
      S_M_EVAL: begin
        cmd_o.m_eval  = 1'b1;
        cmd_o.ptr_clr = sts_i.ptr_last;
        cmd_o.ptr_inc = !sts_i.ptr_last;
      end
      S_C_EVAL: begin
        if (!sts_i.elig || (sts_i.m_vld && sts_i.is_master && sts_i.fv_slave)) begin
          cmd_o.ptr_inc = !sts_i.ptr_last;
        end else if (sts_i.m_vld && sts_i.is_master && sts_i.fv_master) begin
          cmd_o.c_set_master = 1'b1;
        end else if (!sts_i.m_vld && sts_i.fv_master) begin
          cmd_o.c_set_none = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      S_C_CMP: begin
        cmd_o.c_take  = !sts_i.c_vld || sts_i.better;
        cmd_o.ptr_inc = !sts_i.ptr_last;
      end
      S_FALLBACK: cmd_o.c_fallback = 1'b1;
      S_UPD_RD:   cmd_o.addr_sel = ADDR_CAND;
      S_UPD_WR: begin
        cmd_o.addr_sel    = ADDR_CAND;
        cmd_o.cnt_wr_pick = sts_i.c_vld;
      end
      S_RESULT: cmd_o.res_load = !sts_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/wlc_dp.sv
// ----------------------------------------------------------------------------
// wlc_dp
// server tables, master and candidate tracking, cost divider, result register
// ----------------------------------------------------------------------------
module wlc_dp
  import wlc_pkg::*;
#(
  parameter int unsigned MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int unsigned CONN_WIDTH  = CONN_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] server_index_i,
  input  logic [5:0] status_bits_i,
  input  logic [9:0] server_weight_i,
  input  logic [7:0] repl_depth_i,
  input  logic       is_active_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic       ok_o,
  output logic [3:0] chosen_index_o,
  output logic [1:0] error_code_o
);

  localparam int unsigned IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned VLD_N = 1 << IDX_W;
  localparam int unsigned CNT_W = CONN_WIDTH + LIFE_W;
  localparam int unsigned NUM_W = CONN_WIDTH + 11;

  // latched transaction
  logic [1:0] mode_q;
  logic [3:0] sidx_q;
  logic [5:0] st_q;
  logic [9:0] wt_q;
  logic [7:0] dp_q;
  logic       act_q;
  logic [4:0] fmask_q, fval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      sidx_q <= server_index_i;
      st_q   <= status_bits_i;
      wt_q   <= server_weight_i;
      dp_q   <= repl_depth_i;
      act_q  <= is_active_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmask_q <= 5'd1;
      fval_q  <= 5'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MASK) begin
        fmask_q <= cfg_wdata_i;
      end else begin
        fval_q <= cfg_wdata_i;
      end
    end
  end

  logic [IDX_W+3:0] sidx_ext;
  logic [IDX_W-1:0] sidx;
  logic             in_range;

  assign sidx_ext = {{IDX_W{1'b0}}, sidx_q};
  assign sidx     = sidx_ext[IDX_W-1:0];
  assign in_range = sidx_ext < (IDX_W + 4)'(MAX_SERVERS);

  // scan pointer
  logic [IDX_W-1:0] ptr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_clr) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + IDX_W'(1);
    end
  end

  logic             c_vld_q;
  logic [IDX_W-1:0] c_idx_q;
  logic [NUM_W-1:0] c_cost_q;
  logic [31:0]      c_life_q;
  logic             m_vld_q;
  logic [IDX_W-1:0] m_idx_q;
  logic [7:0]       m_dp_q;
  logic [9:0]       m_wt_q;

  logic [IDX_W-1:0] addr;
  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_IDX:  addr = sidx;
      ADDR_CAND: addr = c_idx_q;
      default:   addr = ptr_q;
    endcase
  end

  // tables, unwritten entries read as zero through the valid bits
  logic [VLD_N-1:0] ent_vld_q, cnt_vld_q;
  logic             rd_ent_vld_q, rd_cnt_vld_q;
  logic [ENT_W-1:0] ent_rdata, ent_r;
  logic [CNT_W-1:0] cnt_rdata, cnt_r, cnt_wdata;
  logic             ent_we, cnt_we;

  assign ent_we = cmd_i.ent_we & in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q    <= '0;
      cnt_vld_q    <= '0;
      rd_ent_vld_q <= 1'b0;
      rd_cnt_vld_q <= 1'b0;
    end else begin
      if (ent_we) begin
        ent_vld_q[addr] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_vld_q[addr] <= 1'b1;
      end
      rd_ent_vld_q <= ent_vld_q[addr];
      rd_cnt_vld_q <= cnt_vld_q[addr];
    end
  end

  wlc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SERVERS)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .addr_i  (addr),
    .wdata_i ({st_q, wt_q, dp_q, act_q}),
    .rdata_o (ent_rdata)
  );

  wlc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SERVERS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .addr_i  (addr),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata)
  );

  assign ent_r = rd_ent_vld_q ? ent_rdata : '0;
  assign cnt_r = rd_cnt_vld_q ? cnt_rdata : '0;

  logic [5:0]            r_st;
  logic [9:0]            r_wt;
  logic [7:0]            r_dp;
  logic                  r_act;
  logic [CONN_WIDTH-1:0] r_cur;
  logic [31:0]           r_life;

  assign r_st   = ent_r[24:19];
  assign r_wt   = ent_r[18:9];
  assign r_dp   = ent_r[8:1];
  assign r_act  = ent_r[0];
  assign r_cur  = cnt_r[CNT_W-1:LIFE_W];
  assign r_life = cnt_r[LIFE_W-1:0];

  // counter updates, saturating
  logic rel_ok_c, rel_ok_q;
  logic [CONN_WIDTH-1:0] cur_inc;
  logic [31:0]           life_inc;

  assign rel_ok_c = in_range & (r_cur != '0);
  assign cur_inc  = (r_cur != '1) ? r_cur + CONN_WIDTH'(1) : r_cur;
  assign life_inc = (r_life != '1) ? r_life + 32'd1 : r_life;
  assign cnt_we   = cmd_i.cnt_wr_pick | (cmd_i.cnt_wr_rel & rel_ok_c);
  assign cnt_wdata = cmd_i.cnt_wr_pick ? {cur_inc, life_inc}
                                       : {r_cur - CONN_WIDTH'(1), r_life};

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_wr_rel) begin
      rel_ok_q <= rel_ok_c;
    end
  end

  // root master tracking
  logic m_better;
  assign m_better = r_act & r_st[ST_RUNNING] & r_st[ST_MASTER] &
                    (!m_vld_q || (r_dp < m_dp_q) || ((r_dp == m_dp_q) && (r_wt > m_wt_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (cmd_i.m_clr) begin
      m_vld_q <= 1'b0;
    end else if (cmd_i.m_eval && m_better) begin
      m_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.m_eval && m_better) begin
      m_idx_q <= ptr_q;
      m_dp_q  <= r_dp;
      m_wt_q  <= r_wt;
    end
  end

  // cost = (conn + 1) * scale / weight
  logic [CONN_WIDTH:0] cur_p1;
  logic [NUM_W-1:0]    num_c, quot;
  logic                div_busy;

  assign cur_p1 = (CONN_WIDTH + 1)'(r_cur) + (CONN_WIDTH + 1)'(1);
  assign num_c  = NUM_W'(cur_p1) * NUM_W'(COST_SCALE);

  wlc_div #(.NUM_W(NUM_W), .DEN_W(10)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_c),
    .den_i   (r_wt),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // candidate tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (cmd_i.c_clr || cmd_i.c_set_none) begin
      c_vld_q <= 1'b0;
    end else if (cmd_i.c_take || cmd_i.c_set_master || (cmd_i.c_fallback && m_vld_q)) begin
      c_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.c_take) begin
      c_idx_q  <= ptr_q;
      c_cost_q <= quot;
      c_life_q <= r_life;
    end else if (cmd_i.c_set_master || (cmd_i.c_fallback && !c_vld_q)) begin
      c_idx_q <= m_idx_q;
    end
  end

  // result register
  logic             out_vld_q, ok_q;
  logic [3:0]       ch_q;
  logic [1:0]       err_q;
  logic [IDX_W+3:0] c_ext;

  assign c_ext = {4'b0, c_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (mode_q)
        MODE_WRITE: begin
          ok_q  <= in_range;
          ch_q  <= sidx_q;
          err_q <= ERR_NONE;
        end
        MODE_PICK: begin
          ok_q  <= c_vld_q;
          ch_q  <= c_vld_q ? c_ext[3:0] : 4'd0;
          err_q <= c_vld_q ? ERR_NONE : ERR_NO_SERVER;
        end
        MODE_RELEASE: begin
          ok_q  <= rel_ok_q;
          ch_q  <= sidx_q;
          err_q <= rel_ok_q ? ERR_NONE : ERR_ZERO_REL;
        end
        default: begin
          ok_q  <= 1'b0;
          ch_q  <= sidx_q;
          err_q <= ERR_NONE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_vld_q;
  assign ok_o           = ok_q;
  assign chosen_index_o = ch_q;
  assign error_code_o   = err_q;

  always_comb begin
    sts_o.ptr_last  = (ptr_q == IDX_W'(MAX_SERVERS - 1));
    sts_o.elig      = r_act & !r_st[ST_MAINT] & (r_wt != 10'd0) & r_st[ST_RUNNING] &
                      ((r_st[4:0] & fmask_q & fval_q) != 5'd0);
    sts_o.is_master = m_vld_q & (m_idx_q == ptr_q);
    sts_o.m_vld     = m_vld_q;
    sts_o.fv_slave  = fval_q[ST_SLAVE];
    sts_o.fv_master = fval_q[ST_MASTER];
    sts_o.div_busy  = div_busy;
    sts_o.better    = (quot < c_cost_q) || ((quot == c_cost_q) && (r_life < c_life_q));
    sts_o.c_vld     = c_vld_q;
    sts_o.out_busy  = out_vld_q & !out_ready_i;
  end

endmodule

>>> design/weighted_least_conn_picker_unit.sv
// ----------------------------------------------------------------------------
// weighted_least_conn_picker_unit
// write and release touch one entry, an unused mode goes straight to the result
// pick: a root master pass over all entries, then a candidate pass that
//   runs the bit serial divider for eligible entries, then the update of
//   the chosen server's counters
// one transaction in flight; the next is taken while a result waits
// async active-low reset: tables read as zero, filters at 1, output empty
// ----------------------------------------------------------------------------
module weighted_least_conn_picker_unit
  import wlc_pkg::*;
#(
  parameter int unsigned MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int unsigned CONN_WIDTH  = CONN_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input transaction
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] server_index_i,
  input  logic [5:0] status_bits_i,
  input  logic [9:0] server_weight_i,
  input  logic [7:0] repl_depth_i,
  input  logic       is_active_i,
  // result transaction
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       ok_o,
  output logic [3:0] chosen_index_o,
  output logic [1:0] error_code_o,
  // filter register writes
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [4:0] cfg_wdata_i
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: runs writes and releases; a pick walks the master pass, then the candidate pass
  wlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: entry and counter memories, trackers, divider, result reg
  wlc_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .CONN_WIDTH  (CONN_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .server_index_i  (server_index_i),
    .status_bits_i   (status_bits_i),
    .server_weight_i (server_weight_i),
    .repl_depth_i    (repl_depth_i),
    .is_active_i     (is_active_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .ok_o            (ok_o),
    .chosen_index_o  (chosen_index_o),
    .error_code_o    (error_code_o)
  );

endmodule

>>> design/wlc_checker.sv
// ----------------------------------------------------------------------------
// wlc_checker
// port level checks on the picker, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wlc_checker
  import wlc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       ok_o,
  input logic [3:0] chosen_index_o,
  input logic [1:0] error_code_o
);

  // one transaction at a time: busy right after an accept
  `WLC_ASSERT(a_busy_after_accept, clk_i, rst_ni,
              (in_valid_i && in_ready_o) |=> !in_ready_o)

  // a stalled result holds
  `WLC_ASSERT(a_out_hold, clk_i, rst_ni,
              (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(ok_o) &&
              $stable(chosen_index_o) && $stable(error_code_o)))

  // success never carries an error
  `WLC_ASSERT_MSG(a_ok_no_err, clk_i, rst_ni,
                  (out_valid_o && ok_o) |-> (error_code_o == ERR_NONE), "ok with error code")

  // failed pick reports index zero
  `WLC_ASSERT_MSG(a_nosrv_idx, clk_i, rst_ni,
                  (out_valid_o && error_code_o == ERR_NO_SERVER) |->
                  (chosen_index_o == 4'd0 && !ok_o), "bad failed pick")

endmodule

bind weighted_least_conn_picker_unit wlc_checker u_wlc_checker (.*);

>>> sim/tb_weighted_least_conn_picker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_least_conn_picker_unit
// checks the server picker against a cycle-free predictor: table writes,
// picks under several filter settings, releases, with random idling on both
// sides, a long receiver hold-off and a drain pause
// ----------------------------------------------------------------------------
module tb_weighted_least_conn_picker_unit;
  import wlc_pkg::*;

  localparam int unsigned NSRV     = 16;
  localparam logic [15:0] CONN_TOP = 16'hFFFF;

  // one input transaction as it goes on the wire
  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] idx;
    logic [5:0] status;
    logic [9:0] weight;
    logic [7:0] depth;
    logic       active;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic       ok;
    logic [3:0] chosen;
    logic [1:0] err;
  } pick_res_t;

  // directed stimulus row: request plus an optional typed-in result
  typedef struct packed {
    req_t      req;
    logic      fixed;
    pick_res_t res;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] mode_i = '0;
  logic [3:0] server_index_i = '0;
  logic [5:0] status_bits_i = '0;
  logic [9:0] server_weight_i = '0;
  logic [7:0] repl_depth_i = '0;
  logic       is_active_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       ok_o;
  logic [3:0] chosen_index_o;
  logic [1:0] error_code_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = CFG_MASK;
  logic [4:0] cfg_wdata_i = '0;

  weighted_least_conn_picker_unit uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [4:0]  flt_mask, flt_value;
  logic [5:0]  tbl_status [NSRV];
  logic [9:0]  tbl_weight [NSRV];
  logic [7:0]  tbl_depth  [NSRV];
  logic        tbl_active [NSRV];
  logic [15:0] cur_conns  [NSRV];
  logic [31:0] life_conns [NSRV];

  pick_res_t pending_results [$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_cycles = 0;

  function automatic logic [63:0] load_cost(int i);
    return ((64'(cur_conns[i]) + 64'd1) * 64'(COST_SCALE)) / 64'(tbl_weight[i]);
  endfunction

  function automatic int root_master();
    int best;
    best = -1;
    for (int i = 0; i < NSRV; i++) begin
      if (!tbl_active[i] || !tbl_status[i][ST_RUNNING] || !tbl_status[i][ST_MASTER]) continue;
      if (best < 0 || tbl_depth[i] < tbl_depth[best] ||
          (tbl_depth[i] == tbl_depth[best] && tbl_weight[i] > tbl_weight[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic int choose_server();
    int master, cand;
    logic [5:0] st;
    master = root_master();
    cand = -1;
    for (int i = 0; i < NSRV; i++) begin
      st = tbl_status[i];
      if (!tbl_active[i] || st[ST_MAINT] || tbl_weight[i] == 0) continue;
      if (!st[ST_RUNNING] || (st[4:0] & flt_mask & flt_value) == 0) continue;
      if (master >= 0) begin
        if (i == master && flt_value[ST_SLAVE]) continue;
        if (i == master && flt_value[ST_MASTER]) begin
          cand = master;
          break;
        end
      end else if (flt_value[ST_MASTER]) begin
        cand = -1;
        break;
      end
      if (cand < 0) cand = i;
      else if (load_cost(i) < load_cost(cand) ||
               (load_cost(i) == load_cost(cand) && life_conns[i] < life_conns[cand]))
        cand = i;
    end
    if (cand < 0) cand = master;
    return cand;
  endfunction

  // applies one transaction to the predictor and returns its result
  function automatic pick_res_t serve_request(req_t r);
    pick_res_t res;
    int c;
    res = '{ok: 1'b0, chosen: r.idx, err: ERR_NONE};
    case (r.mode)
      MODE_WRITE: begin
        tbl_status[r.idx] = r.status;
        tbl_weight[r.idx] = r.weight;
        tbl_depth[r.idx]  = r.depth;
        tbl_active[r.idx] = r.active;
        res.ok = 1'b1;
      end
      MODE_PICK: begin
        c = choose_server();
        if (c < 0) begin
          res.chosen = '0;
          res.err = ERR_NO_SERVER;
        end else begin
          if (cur_conns[c] != CONN_TOP) cur_conns[c]++;
          if (life_conns[c] != 32'hFFFF_FFFF) life_conns[c]++;
          res.chosen = c[3:0];
          res.ok = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (cur_conns[r.idx] != 0) begin
          cur_conns[r.idx]--;
          res.ok = 1'b1;
        end else res.err = ERR_ZERO_REL;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // result side: random stall, long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result check at the rising edge
  always @(posedge clk_i) begin
    pick_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("result with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) report_mismatch("ok", ok_o, want.ok);
        if (chosen_index_o !== want.chosen)
          report_mismatch("chosen_index", chosen_index_o, want.chosen);
        if (error_code_o !== want.err) report_mismatch("error_code", error_code_o, want.err);
      end
    end
  end

  // offers one transaction, checks a typed-in result too if given
  task automatic send_request(req_t r, logic fixed = 1'b0, pick_res_t res = '0);
    pick_res_t p;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    {mode_i, server_index_i, status_bits_i, server_weight_i, repl_depth_i, is_active_i} = r;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    p = serve_request(r);
    if (fixed && p !== res) report_mismatch("predictor vs table", p, res);
    pending_results.push_back(p);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
  endtask

  task automatic write_filter(logic idx, logic [4:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_MASK) flt_mask = val;
    else flt_value = val;
  endtask

  function automatic req_t random_request();
    req_t r;
    int sel;
    r = req_t'(31'($urandom));
    sel = $urandom_range(99);
    if (sel < 30) r.mode = MODE_WRITE;
    else if (sel < 75) r.mode = MODE_PICK;
    else if (sel < 97) r.mode = MODE_RELEASE;
    else r.mode = 2'd3;
    // mostly sane servers so picks get past the filters
    if (r.mode == MODE_WRITE && $urandom_range(3) != 0) begin
      r.weight = 10'($urandom_range(1000, 1));
      r.status[ST_RUNNING] = 1'b1;
      r.status[ST_MAINT] = ($urandom_range(7) == 0);
      r.active = ($urandom_range(7) != 0);
      r.depth = 8'($urandom_range(3));
    end
    return r;
  endfunction

  // directed rows: the fixed ones have their result read off directly
  row_t dir_rows [] = '{
    '{'{MODE_PICK, 4'd0, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b1, '{1'b0, 4'd0, ERR_NO_SERVER}},
    '{'{MODE_RELEASE, 4'd15, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b1, '{1'b0, 4'd15, ERR_ZERO_REL}},
    '{'{2'd3, 4'd9, 6'h3F, 10'd1000, 8'd255, 1'b1}, 1'b1, '{1'b0, 4'd9, ERR_NONE}},
    '{'{MODE_WRITE, 4'd15, 6'h3F, 10'd1000, 8'd255, 1'b1}, 1'b1, '{1'b1, 4'd15, ERR_NONE}},
    '{'{MODE_PICK, 4'd0, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b1, '{1'b1, 4'd15, ERR_NONE}},
    '{'{MODE_WRITE, 4'd0, 6'h03, 10'd1, 8'd0, 1'b1}, 1'b1, '{1'b1, 4'd0, ERR_NONE}},
    '{'{MODE_WRITE, 4'd1, 6'h05, 10'd1000, 8'd4, 1'b1}, 1'b0, '0},
    '{'{MODE_WRITE, 4'd2, 6'h19, 10'd500, 8'd2, 1'b1}, 1'b0, '0},
    '{'{MODE_WRITE, 4'd3, 6'h01, 10'd0, 8'd0, 1'b1}, 1'b0, '0},
    '{'{MODE_WRITE, 4'd4, 6'h21, 10'd700, 8'd1, 1'b1}, 1'b0, '0},
    '{'{MODE_PICK, 4'd0, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_PICK, 4'd0, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_PICK, 4'd0, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_RELEASE, 4'd1, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_RELEASE, 4'd3, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b1, '{1'b0, 4'd3, ERR_ZERO_REL}},
    '{'{MODE_WRITE, 4'd15, 6'h00, 10'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_PICK, 4'd0, 6'd0, 10'd0, 8'd0, 1'b0}, 1'b0, '0}
  };

  // filter settings walked by the random phases: mask, value
  logic [4:0] flt_sets [6][2] = '{
    '{5'd1, 5'd1}, '{5'd31, 5'd31}, '{5'd0, 5'd0},
    '{5'd7, 5'd3}, '{5'd7, 5'd5}, '{5'd31, 5'd24}
  };

  initial begin
    flt_mask = 5'd1;
    flt_value = 5'd1;
    for (int i = 0; i < NSRV; i++) begin
      tbl_status[i] = '0; tbl_weight[i] = '0; tbl_depth[i] = '0;
      tbl_active[i] = 1'b0; cur_conns[i] = '0; life_conns[i] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].res);

    // random phases, each under its own filter setting, with one of three idling profiles
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_filter(CFG_MASK, flt_sets[ph][0]);
      write_filter(CFG_VALUE, flt_sets[ph][1]);
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 67 : 0;
      recv_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 10 : 0;
      for (int n = 0; n < 180; n++) begin
        if (ph == 4 && n == 20) hold_cycles = 3000;
        send_request(random_request());
      end
    end

    // a burst of picks to push counts up
    for (int n = 0; n < 40; n++) send_request('{MODE_PICK, 4'($urandom), 6'd0, 10'd0, 8'd0, 1'b0});

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
